// ===== rtl/sorted_table_binary_search_top_macros.svh =====
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define STBS_CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define STBS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stbs_pkg.sv =====
package stbs_pkg;

    localparam int STBS_DEPTH     = 1024;
    localparam int STBS_KEY_WIDTH = 32;

    localparam int SLOT_W      = 10;
    localparam int KEY_VALUE_W = 32;
    localparam int COUNT_W     = 11;
    localparam int POS_W       = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_KEYS = 1'b1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef struct packed {
        logic                   kind;
        logic [SLOT_W-1:0]      slot;
        logic [KEY_VALUE_W-1:0] key_value;
        logic                   want_match;
        logic                   stable_order;
    } stbs_req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } stbs_rsp_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ_LAST,
        OP_READ_FIRST,
        OP_INIT,
        OP_STEP,
        OP_DOWN_START,
        OP_DOWN_STEP,
        OP_UP_STEP
    } stbs_op_t;

    typedef enum logic [2:0] {
        POS_ZERO,
        POS_N,
        POS_N_M1,
        POS_MID,
        POS_MID_P1,
        POS_MID_M1
    } stbs_pos_sel_t;

    typedef struct packed {
        logic          load;
        stbs_op_t      op;
        logic          res_set;
        logic          res_found;
        stbs_pos_sel_t res_pos;
        logic          out_load;
    } stbs_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic want_match;
        logic stable;
        logic lt;
        logic eq;
        logic mid_zero;
        logic mid_one;
        logic mid_p1_ge_n;
        logic step_done;
    } stbs_status_t;

endpackage

// ===== rtl/stbs_datapath.sv =====
module stbs_datapath
    import stbs_pkg::*;
#(
    parameter int DEPTH     = STBS_DEPTH,
    parameter int KEY_WIDTH = STBS_KEY_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  stbs_req_t              req,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  stbs_cmd_t              cmd,
    output stbs_status_t           status,
    output stbs_rsp_t              rsp
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int EXT_W  = CNT_W + COUNT_W;

    logic [KEY_WIDTH-1:0] key_table_reg [DEPTH];
    logic [KEY_WIDTH-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 mem_we;
    logic                 slot_ok;

    logic [COUNT_W-1:0]   entry_count_reg;
    logic                 signed_keys_reg;

    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 want_match_reg, want_match_next;
    logic                 stable_reg, stable_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [CNT_W-1:0]     mid_reg, mid_next;
    logic                 found_res_reg, found_res_next;
    logic [POS_W-1:0]     pos_res_reg, pos_res_next;
    stbs_rsp_t            rsp_reg, rsp_next;

    logic [CNT_W-1:0]     n_load;
    logic [KEY_WIDTH-1:0] sign_flip;
    logic [KEY_WIDTH-1:0] key_ord;
    logic [KEY_WIDTH-1:0] data_ord;
    logic                 cmp_lt;
    logic                 cmp_eq;
    logic                 cmp_gt;
    logic [CNT_W-1:0]     mid_p1;
    logic [CNT_W-1:0]     mid_m1;
    logic [CNT_W-1:0]     mid_m2;
    logic [CNT_W-1:0]     n_m1;
    logic [CNT_W-1:0]     mid_init;
    logic [CNT_W-1:0]     lo_step;
    logic [CNT_W-1:0]     hi_step;
    logic [SUM_W-1:0]     step_sum;
    logic [CNT_W-1:0]     mid_step;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            signed_keys_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_SIGNED_KEYS: signed_keys_reg <= cfg_data[0];
                default:         entry_count_reg <= entry_count_reg;
            endcase
        end
    end

    assign slot_ok = EXT_W'(req.slot) < EXT_W'(DEPTH);
    assign mem_we  = cmd.load && (req.kind == KIND_WRITE) && slot_ok;
    assign wr_addr = ADDR_W'(req.slot);
    assign n_load  = (EXT_W'(entry_count_reg) > EXT_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                               : CNT_W'(entry_count_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_table_reg[wr_addr] <= KEY_WIDTH'(req.key_value);
        end
        rd_data_reg <= key_table_reg[rd_addr];
    end

    // Signed order is unsigned order with the sign bit inverted.
    assign sign_flip = {signed_keys_reg, {(KEY_WIDTH-1){1'b0}}};
    assign key_ord   = key_reg ^ sign_flip;
    assign data_ord  = rd_data_reg ^ sign_flip;
    assign cmp_lt    = key_ord < data_ord;
    assign cmp_eq    = key_ord == data_ord;
    assign cmp_gt    = !cmp_lt && !cmp_eq;

    assign mid_p1   = mid_reg + CNT_W'(1);
    assign mid_m1   = mid_reg - CNT_W'(1);
    assign mid_m2   = mid_reg - CNT_W'(2);
    assign n_m1     = n_reg - CNT_W'(1);
    assign mid_init = n_m1 >> 1;
    assign lo_step  = cmp_gt ? mid_p1 : lo_reg;
    assign hi_step  = cmp_lt ? mid_reg : hi_reg;
    assign step_sum = SUM_W'(lo_step) + SUM_W'(hi_step) - SUM_W'(1);
    assign mid_step = CNT_W'(step_sum >> 1);

    always_comb
    begin
        case (cmd.op)
            OP_READ_LAST:  rd_addr = ADDR_W'(n_m1);
            OP_READ_FIRST: rd_addr = '0;
            OP_INIT:       rd_addr = ADDR_W'(mid_init);
            OP_STEP:       rd_addr = ADDR_W'(mid_step);
            OP_DOWN_START: rd_addr = ADDR_W'(mid_m1);
            OP_DOWN_STEP:  rd_addr = ADDR_W'(mid_m2);
            OP_UP_STEP:    rd_addr = ADDR_W'(mid_p1);
            default:       rd_addr = ADDR_W'(mid_reg);
        endcase
    end

    always_comb
    begin
        key_next        = key_reg;
        want_match_next = want_match_reg;
        stable_next     = stable_reg;
        n_next          = n_reg;
        if (cmd.load)
        begin
            key_next        = KEY_WIDTH'(req.key_value);
            want_match_next = req.want_match;
            stable_next     = req.stable_order;
            n_next          = n_load;
        end
    end

    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        mid_next = mid_reg;
        case (cmd.op)
            OP_INIT:
            begin
                lo_next  = '0;
                hi_next  = n_reg;
                mid_next = mid_init;
            end
            OP_STEP:
            begin
                lo_next  = lo_step;
                hi_next  = hi_step;
                mid_next = mid_step;
            end
            OP_DOWN_STEP: mid_next = mid_m1;
            OP_UP_STEP:   mid_next = mid_p1;
            default:      mid_next = mid_reg;
        endcase
    end

    always_comb
    begin
        found_res_next = found_res_reg;
        pos_res_next   = pos_res_reg;
        if (cmd.res_set)
        begin
            found_res_next = cmd.res_found;
            case (cmd.res_pos)
                POS_N:      pos_res_next = POS_W'(n_reg);
                POS_N_M1:   pos_res_next = POS_W'(n_m1);
                POS_MID:    pos_res_next = POS_W'(mid_reg);
                POS_MID_P1: pos_res_next = POS_W'(mid_p1);
                POS_MID_M1: pos_res_next = POS_W'(mid_m1);
                default:    pos_res_next = '0;
            endcase
        end
    end

    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.out_load)
        begin
            rsp_next.found    = found_res_reg;
            rsp_next.position = pos_res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        want_match_reg <= want_match_next;
        stable_reg     <= stable_next;
        n_reg          <= n_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        found_res_reg  <= found_res_next;
        pos_res_reg    <= pos_res_next;
        rsp_reg        <= rsp_next;
    end

    assign status.n_zero      = n_reg == '0;
    assign status.want_match  = want_match_reg;
    assign status.stable      = stable_reg;
    assign status.lt          = cmp_lt;
    assign status.eq          = cmp_eq;
    assign status.mid_zero    = mid_reg == '0;
    assign status.mid_one     = mid_reg == CNT_W'(1);
    assign status.mid_p1_ge_n = mid_p1 >= n_reg;
    assign status.step_done   = lo_step >= hi_step;

    assign rsp = rsp_reg;

endmodule

// ===== rtl/stbs_ctrl.sv =====
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  logic         req_kind,
    output logic         req_stall,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    input  stbs_status_t status,
    output stbs_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CHECK  = 8'b0000_0010,
        ST_LAST   = 8'b0000_0100,
        ST_FIRST  = 8'b0000_1000,
        ST_PROBE  = 8'b0001_0000,
        ST_DOWN   = 8'b0010_0000,
        ST_UP     = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } stbs_state_t;

    stbs_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        cmp_gt;

    assign cmp_gt = !status.lt && !status.eq;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        cmd.load       = 1'b0;
        cmd.op         = OP_NONE;
        cmd.res_set    = 1'b0;
        cmd.res_found  = 1'b0;
        cmd.res_pos    = POS_ZERO;
        cmd.out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (req_kind == KIND_SEARCH)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (status.n_zero)
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_found = !status.want_match;
                    state_next    = ST_FINISH;
                end
                else if (!status.stable)
                begin
                    cmd.op     = OP_READ_LAST;
                    state_next = ST_LAST;
                end
                else
                begin
                    cmd.op     = OP_INIT;
                    state_next = ST_PROBE;
                end
            end
            ST_LAST:
            begin
                if (status.eq)
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_found = 1'b1;
                    cmd.res_pos   = status.want_match ? POS_N_M1 : POS_N;
                    state_next    = ST_FINISH;
                end
                else if (cmp_gt)
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_found = !status.want_match;
                    cmd.res_pos   = status.want_match ? POS_ZERO : POS_N;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.op     = OP_READ_FIRST;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (status.lt)
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_found = !status.want_match;
                    state_next    = ST_FINISH;
                end
                else if (status.eq)
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_found = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.op     = OP_INIT;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (status.eq)
                begin
                    if (!status.stable || (status.want_match && status.mid_zero))
                    begin
                        cmd.res_set   = 1'b1;
                        cmd.res_found = 1'b1;
                        cmd.res_pos   = POS_MID;
                        state_next    = ST_FINISH;
                    end
                    else if (status.want_match)
                    begin
                        cmd.op     = OP_DOWN_START;
                        state_next = ST_DOWN;
                    end
                    else
                    begin
                        cmd.op = OP_UP_STEP;
                        if (status.mid_p1_ge_n)
                        begin
                            cmd.res_set   = 1'b1;
                            cmd.res_found = 1'b1;
                            cmd.res_pos   = POS_MID_P1;
                            state_next    = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_UP;
                        end
                    end
                end
                else if (status.step_done)
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_found = !status.want_match;
                    if (!status.want_match)
                    begin
                        cmd.res_pos = cmp_gt ? POS_MID_P1 : POS_MID;
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.op = OP_STEP;
                end
            end
            ST_DOWN:
            begin
                if (status.eq && !status.mid_one)
                begin
                    cmd.op = OP_DOWN_STEP;
                end
                else
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_found = 1'b1;
                    cmd.res_pos   = status.eq ? POS_MID_M1 : POS_MID;
                    state_next    = ST_FINISH;
                end
            end
            ST_UP:
            begin
                if (status.eq)
                begin
                    cmd.op = OP_UP_STEP;
                    if (status.mid_p1_ge_n)
                    begin
                        cmd.res_set   = 1'b1;
                        cmd.res_found = 1'b1;
                        cmd.res_pos   = POS_MID_P1;
                        state_next    = ST_FINISH;
                    end
                end
                else
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_found = 1'b1;
                    cmd.res_pos   = POS_MID;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = state_reg != ST_IDLE;
    assign rsp_valid = out_valid_reg;

endmodule

// ===== rtl/sorted_table_binary_search_top.sv =====
// Channel   Handshake              Payload                  Direction
// req       req_valid / req_stall  stbs_req_t req           into the block
// rsp       rsp_valid / rsp_stall  stbs_rsp_t rsp           out of the block
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data      into the block
//
// A write item leaves the block idle, ready for the next item. A search reads the table
// one probe at a time, since each probe address follows from the previous compare.
// With stable order the search walks an equal run entry by entry to its first or last entry.
// Reset clears the configuration and control state; the table is undefined until written.
// A finished result waits in the output register while the next item is accepted.
// Configuration writes are always taken and must only be issued while the block is idle.
module sorted_table_binary_search_top
    import stbs_pkg::*;
#(
    parameter int DEPTH     = STBS_DEPTH,
    parameter int KEY_WIDTH = STBS_KEY_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  stbs_req_t              req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output stbs_rsp_t              rsp,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "sorted_table_binary_search_top_macros.svh"

    stbs_cmd_t    cmd;
    stbs_status_t status;
    logic         cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    stbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    stbs_datapath #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .rsp       (rsp)
    );

    `STBS_CHECK_NEXT(a_write_returns_idle,
        req_valid && !req_stall && req.kind == KIND_WRITE,
        !req_stall, "write item left the controller busy")
    `STBS_CHECK_NEXT(a_search_goes_busy,
        req_valid && !req_stall && req.kind == KIND_SEARCH,
        req_stall, "search item did not start a search")
    `STBS_CHECK_SAME(a_result_after_search,
        $rose(rsp_valid), $past(req_stall),
        "result appeared without a search in flight")
    `STBS_CHECK_SAME(a_miss_position_zero,
        rsp_valid && !rsp.found, rsp.position == '0,
        "missed search reported a nonzero position")

endmodule
